// File: rtl/lru_recency_list_top_macros.svh
// Assertion macros used by the LRU recency list datapath.
`ifndef LRU_RECENCY_LIST_TOP_MACROS_SVH
`define LRU_RECENCY_LIST_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru recency list check failed");
`define LRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru recency list check failed");
`else
`define LRL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/lrl_pkg.sv
// Shared widths and controller-to-datapath command type of the LRU recency list.
package lrl_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 5;
  localparam int OCC_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  typedef struct packed {
    logic step;
    logic cfg_load;
  } cmd_t;

endpackage

// File: rtl/lrl_ctrl.sv
// Controller of the LRU recency list: input and output handshakes and the result register state.
module lrl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_wr_en,
  output lrl_pkg::cmd_t cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_HOLD  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic hold_busy;

  assign hold_busy    = (state_r == ST_HOLD) && out_stall;
  assign in_stall     = !rst_n || hold_busy;
  assign out_valid    = (state_r == ST_HOLD);
  assign cmd.step     = in_valid && !in_stall;
  assign cmd.cfg_load = cfg_wr_en;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (cmd.step) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (cmd.step) begin
          state_nxt = ST_HOLD;
        end else if (!out_stall) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/lrl_dpath.sv
// Datapath of the LRU recency list: key shift chain, parallel match, count and result registers.
`include "lru_recency_list_top_macros.svh"
module lrl_dpath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrl_pkg::cmd_t                     cmd,
  input  logic [lrl_pkg::CAP_W-1:0]         cfg_wr_data,
  input  logic signed [lrl_pkg::KEY_W-1:0]  in_access_key,
  output logic                              out_hit,
  output logic                              out_evicted,
  output logic signed [lrl_pkg::KEY_W-1:0]  out_evicted_key,
  output logic [lrl_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int EW = (CW > lrl_pkg::CAP_W) ? CW : lrl_pkg::CAP_W;

  function automatic logic [CW-1:0] eff_cap(input logic [lrl_pkg::CAP_W-1:0] c);
    logic [EW-1:0] cx;
    logic [CW-1:0] r;
    cx = EW'(c);
    if (c == '0) begin
      r = CW'(1);
    end else if (cx > EW'(MAX_ENTRIES)) begin
      r = CW'(MAX_ENTRIES);
    end else begin
      r = CW'(cx);
    end
    return r;
  endfunction

  logic [lrl_pkg::KEY_W-1:0] entries_r [MAX_ENTRIES];
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [lrl_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]             cap_eff;
  logic [CW-1:0]             cfg_cap_eff;
  logic [lrl_pkg::KEY_W-1:0] key_u;
  logic [MAX_ENTRIES-1:0]    match;
  logic [MAX_ENTRIES-1:0]    seen;
  logic [MAX_ENTRIES-1:0]    shift_en;
  logic                      hit;
  logic                      full;
  logic                      evict;
  logic [CW-1:0]             cnt_dec;
  logic [CW-1:0]             upto;
  logic [IW-1:0]             ev_idx;
  logic                      hit_r;
  logic                      evicted_r;
  logic [lrl_pkg::KEY_W-1:0] ev_key_r;
  logic [lrl_pkg::OCC_W-1:0] occ_r;

  assign key_u       = $unsigned(in_access_key);
  assign cap_eff     = eff_cap(cap_r);
  assign cfg_cap_eff = eff_cap(cfg_wr_data);
  assign full        = (count_r >= cap_eff);
  assign cnt_dec     = count_r - CW'(1);
  assign ev_idx      = cnt_dec[IW-1:0];
  assign upto        = full ? cnt_dec : count_r;
  assign hit         = |match;
  assign evict       = !hit && full;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (CW'(i) < count_r) && (entries_r[i] == key_u);
    end
    seen[0] = 1'b0;
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      seen[i] = seen[i-1] | match[i-1];
    end
    shift_en[0] = 1'b0;
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      shift_en[i] = hit ? !seen[i] : (CW'(i) <= upto);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cfg_load && (count_r > cfg_cap_eff)) begin
      count_nxt = cfg_cap_eff;
    end else if (cmd.step && !hit && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= lrl_pkg::CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cmd.cfg_load) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      entries_r[0] <= key_u;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        if (shift_en[i]) begin
          entries_r[i] <= entries_r[i-1];
        end
      end
      hit_r     <= hit;
      evicted_r <= evict;
      ev_key_r  <= evict ? entries_r[ev_idx] : '0;
      occ_r     <= lrl_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_hit         = hit_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = $signed(ev_key_r);
  assign out_occupancy   = occ_r;

  `LRL_ASSERT_NOW(a_count_in_cap, clk, rst_n, 1'b1, count_r <= cap_eff)
  `LRL_ASSERT_NEXT(a_front_key, clk, rst_n, cmd.step, entries_r[0] == $past(key_u))
  `LRL_ASSERT_NEXT(a_evict_count, clk, rst_n, cmd.step && evict, count_r == $past(count_r) && evicted_r)
  `LRL_ASSERT_NEXT(a_hit_no_evict, clk, rst_n, cmd.step, !(hit_r && evicted_r))

endmodule

// File: rtl/lru_recency_list_top.sv
// Top level of the LRU recency list: controller and datapath.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall    in_access_key
//   out_      output     out_valid / out_stall  out_hit, out_evicted, out_evicted_key,
//                                               out_occupancy
//   cfg_      input      cfg_wr_en              cfg_wr_data (capacity)
//
// A word is looked up, reordered and registered in the cycle it is accepted; the
// result word appears on the output register in the next cycle, so one word per cycle
// is taken while results drain. The parallel match over all entries and the one-place
// shift of the key chain are done in that cycle. Reset clears the entry count and sets
// capacity to ten; no clearing pass is needed. A stalled result blocks further input.
module lru_recency_list_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lrl_pkg::KEY_W-1:0]  in_access_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic                              out_evicted,
  output logic signed [lrl_pkg::KEY_W-1:0]  out_evicted_key,
  output logic [lrl_pkg::OCC_W-1:0]         out_occupancy,
  input  logic                              cfg_wr_en,
  input  logic [lrl_pkg::CAP_W-1:0]         cfg_wr_data
);

  lrl_pkg::cmd_t cmd;

  lrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_wr_en (cfg_wr_en),
    .cmd       (cmd)
  );

  lrl_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_wr_data     (cfg_wr_data),
    .in_access_key   (in_access_key),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy)
  );

endmodule
